// File: src/integer_to_text_formatter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer to text formatter
// Shared property forms used by the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_TEXT_FORMATTER_DEFINES_SVH
`define INTEGER_TO_TEXT_FORMATTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITF_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/itf_pkg.sv
// ----------------------------------------------------------------------------
// Integer to text formatter package
// Types, codes and character tables shared by the front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none

package itf_pkg;

  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 5;
  localparam int OUT_TDATA_W = 8;

  // Digit store: enough for 22 octal digits of a 64-bit operand.
  localparam int NDIG   = 22;
  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    FUNC_SDEC,
    FUNC_UDEC,
    FUNC_OCT,
    FUNC_HEX,
    FUNC_UHEX,
    FUNC_PTR,
    FUNC_CHAR,
    FUNC_NONE
  } itf_func_e;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_OCT,
    BASE_HEX
  } itf_base_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_PLAN,
    ST_EMIT
  } itf_state_e;

  localparam logic [1:0] SIZE_16 = 2'd0;
  localparam logic [1:0] SIZE_32 = 2'd1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;

  localparam logic [127:0] LOWER_DIGITS = "0123456789abcdef";
  localparam logic [127:0] UPPER_DIGITS = "0123456789ABCDEF";

  typedef struct packed {
    logic       is_char;
    itf_base_e  base;
    logic       upper;
    logic [1:0] size_sel;
    logic [63:0] mag;
    logic [7:0] sign_ch;
    logic [1:0] alt_len;
    logic [7:0] alt_ch;
    logic       has_width;
    logic [6:0] width;
    logic       has_prec;
    logic [5:0] prec;
    logic       left;
    logic       zero;
  } itf_job_t;

  // The first character of a string literal sits in the top byte.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [127:0] tab;
    tab = upper ? UPPER_DIGITS : LOWER_DIGITS;
    return tab[{~d, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

// File: src/itf_front.sv
// ----------------------------------------------------------------------------
// Integer to text formatter front end
// Unpacks an input item, works out magnitude, sign and prefix, and queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module itf_front import itf_pkg::*; (
  input  wire logic                  s_tvalid_i,
  output logic                       s_tready_o,
  input  wire logic [IN_TDATA_W-1:0] s_tdata_i,
  input  wire logic [IN_TUSER_W-1:0] s_tuser_i,
  input  wire logic                  q_ready_i,
  output logic                       push_o,
  output itf_job_t                   job_o
);

  itf_func_e   func;
  logic [1:0]  size_sel;
  logic [63:0] value;
  logic [63:0] sized;
  logic [63:0] mask;
  logic [63:0] neg_mag;
  logic        top_bit;
  logic        neg;
  logic        alt;
  logic        is_char;

  assign func     = itf_func_e'(s_tuser_i[2:0]);
  assign size_sel = s_tuser_i[4:3];
  assign value    = s_tdata_i[63:0];
  assign is_char  = (func == FUNC_CHAR);

  always_comb begin
    case (size_sel)
      SIZE_16: begin
        mask    = 64'h0000_0000_0000_FFFF;
        top_bit = value[15];
      end
      SIZE_32: begin
        mask    = 64'h0000_0000_FFFF_FFFF;
        top_bit = value[31];
      end
      default: begin
        mask    = '1;
        top_bit = value[63];
      end
    endcase
  end

  // The most negative value negates onto itself, which is its exact magnitude.
  assign sized   = value & mask;
  assign neg_mag = (~sized + 64'd1) & mask;
  assign neg     = (func == FUNC_SDEC) && top_bit;
  assign alt     = !is_char && (s_tdata_i[82] || (func == FUNC_PTR));

  always_comb begin
    job_o           = '0;
    job_o.is_char   = is_char;
    job_o.size_sel  = size_sel;
    job_o.mag       = is_char ? value : (neg ? neg_mag : sized);
    job_o.upper     = (func == FUNC_UHEX) || (func == FUNC_PTR);
    job_o.has_width = s_tdata_i[64];
    job_o.width     = s_tdata_i[71:65];
    job_o.has_prec  = s_tdata_i[72];
    job_o.prec      = s_tdata_i[78:73];
    job_o.left      = s_tdata_i[79];
    job_o.zero      = s_tdata_i[83];

    case (func)
      FUNC_OCT:                      job_o.base = BASE_OCT;
      FUNC_HEX, FUNC_UHEX, FUNC_PTR: job_o.base = BASE_HEX;
      default:                       job_o.base = BASE_DEC;
    endcase

    if (!is_char) begin
      if (neg) begin
        job_o.sign_ch = CH_MINUS;
      end else if (s_tdata_i[80]) begin
        job_o.sign_ch = CH_PLUS;
      end else if (s_tdata_i[81]) begin
        job_o.sign_ch = CH_SPACE;
      end
    end

    if (alt) begin
      job_o.alt_len = (func == FUNC_OCT) ? 2'd1 : 2'd2;
      case (func)
        FUNC_HEX:            job_o.alt_ch = CH_LX;
        FUNC_UHEX, FUNC_PTR: job_o.alt_ch = CH_UX;
        default:             job_o.alt_ch = CH_HASH;
      endcase
    end
  end

  // An item with the empty conversion code is taken and dropped here.
  assign s_tready_o = q_ready_i;
  assign push_o     = s_tvalid_i && q_ready_i && (func != FUNC_NONE);

endmodule

`default_nettype wire

// File: src/itf_queue.sv
// ----------------------------------------------------------------------------
// Integer to text formatter job queue
// A short first-in first-out buffer between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module itf_queue import itf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire itf_job_t job_i,
  output logic          ready_o,
  output logic          valid_o,
  output itf_job_t      job_o,
  input  wire logic     pop_i
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CNTW = $clog2(QDEPTH + 1);

  itf_job_t        entry_q [QDEPTH];
  logic [PW-1:0]   wptr_q;
  logic [PW-1:0]   rptr_q;
  logic [CNTW-1:0] count_q;
  logic [CNTW-1:0] count_d;

  assign ready_o = (count_q != CNTW'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = entry_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CNTW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wptr_q <= wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

// File: src/itf_back.sv
// ----------------------------------------------------------------------------
// Integer to text formatter back end
// Extracts digits, lays out the field and sends one character per item.
// ----------------------------------------------------------------------------
`default_nettype none

module itf_back import itf_pkg::*; #(
  parameter int MAX_CHARS = 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   q_valid_i,
  input  wire itf_job_t               q_job_i,
  output logic                        q_pop_o,
  output logic                        m_tvalid_o,
  input  wire logic                   m_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_tdata_o,
  output logic                        m_tlast_o
);

  localparam int CW = $clog2(MAX_CHARS + 128);
  localparam int NW = $clog2(NDIG + 1);
  localparam int IW = $clog2(NDIG);
  localparam int DW = NDIG * 4;

  itf_state_e state_q;
  itf_state_e state_d;

  itf_job_t        job_q;
  logic [63:0]     sh_q;
  logic [3:0]      step_q;
  logic [DW-1:0]   dig_q;
  logic [NW-1:0]   nd_q;
  logic [CW-1:0]   dlen_q;
  logic [CW-1:0]   b1_q, b2_q, b3_q, b4_q, b5_q;
  logic [CW-1:0]   last_q;
  logic [CW-1:0]   pos_q;
  logic [IW-1:0]   didx_q;
  logic            m_tvalid_q;
  logic [7:0]      m_tdata_q;
  logic            m_tlast_q;

  logic            out_free;
  logic            emit_go;

  // Loading a job
  logic [63:0]     aligned_c;
  logic [3:0]      steps_c;
  logic [DW-1:0]   dig_load_c;
  logic [65:0]     oct_ext;
  logic            direct_c;

  // Digit extraction and layout
  logic [DW-1:0]   bcd_c;
  logic [NW-1:0]   nd_c;
  logic [CW-1:0]   signlen_w;
  logic [CW-1:0]   altlen_w;
  logic [CW-1:0]   lim_c;
  logic [CW-1:0]   dlen_c;
  logic [CW-1:0]   body_c;
  logic [CW-1:0]   wcap_c;
  logic [CW-1:0]   total_c;
  logic [CW-1:0]   pad_c;
  logic [CW-1:0]   zeros_c;
  logic [CW-1:0]   b1_c, b2_c, b3_c, b4_c;

  // Character selection
  logic [7:0]      emit_ch;
  logic            emit_digit;

  assign out_free   = !m_tvalid_q || m_tready_i;
  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tlast_o  = m_tlast_q;

  assign direct_c = q_job_i.is_char || (q_job_i.base != BASE_DEC);

  always_comb begin
    case (q_job_i.size_sel)
      SIZE_16: begin
        aligned_c = {q_job_i.mag[15:0], 48'd0};
        steps_c   = 4'd3;
      end
      SIZE_32: begin
        aligned_c = {q_job_i.mag[31:0], 32'd0};
        steps_c   = 4'd7;
      end
      default: begin
        aligned_c = q_job_i.mag;
        steps_c   = 4'd15;
      end
    endcase
  end

  // Octal and hex digits are plain bit fields of the magnitude.
  assign oct_ext = {2'b00, q_job_i.mag};

  always_comb begin
    dig_load_c = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (q_job_i.base == BASE_OCT) begin
        dig_load_c[4*i +: 4] = {1'b0, oct_ext[3*i +: 3]};
      end else if (i < 16) begin
        dig_load_c[4*i +: 4] = q_job_i.mag[4*i +: 4];
      end
    end
  end

  // Four double-dabble steps per cycle, most significant operand bits first.
  always_comb begin
    bcd_c = dig_q;
    for (int s = 0; s < 4; s++) begin
      for (int k = 0; k < NDIG; k++) begin
        if (bcd_c[4*k +: 4] >= 4'd5) begin
          bcd_c[4*k +: 4] = bcd_c[4*k +: 4] + 4'd3;
        end
      end
      bcd_c = {bcd_c[DW-2:0], sh_q[63-s]};
    end
  end

  assign signlen_w = CW'(job_q.sign_ch != 8'd0);
  assign altlen_w  = CW'(job_q.alt_len);
  assign lim_c     = CW'(MAX_CHARS) - signlen_w - altlen_w;

  always_comb begin
    nd_c = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (dig_q[4*i +: 4] != 4'd0) begin
        nd_c = NW'(i + 1);
      end
    end
    if (job_q.is_char) begin
      nd_c = NW'(job_q.mag[7:0] != 8'd0);
    end else if ((nd_c == '0) && !job_q.has_prec) begin
      nd_c = NW'(1);
    end

    dlen_c = CW'(nd_c);
    if (!job_q.is_char) begin
      if (job_q.has_prec && (CW'(job_q.prec) > dlen_c)) begin
        dlen_c = CW'(job_q.prec);
      end
      if (job_q.zero && job_q.has_width && !job_q.left &&
          (CW'(job_q.width) > signlen_w) &&
          ((CW'(job_q.width) - signlen_w) > dlen_c)) begin
        dlen_c = CW'(job_q.width) - signlen_w;
      end
      if (dlen_c > lim_c) begin
        dlen_c = lim_c;
      end
    end
  end

  always_comb begin
    body_c = altlen_w + signlen_w + dlen_q;
    if (!job_q.has_width) begin
      wcap_c = '0;
    end else if (CW'(job_q.width) > CW'(MAX_CHARS)) begin
      wcap_c = CW'(MAX_CHARS);
    end else begin
      wcap_c = CW'(job_q.width);
    end
    total_c = (wcap_c > body_c) ? wcap_c : body_c;
    pad_c   = total_c - body_c;
    zeros_c = (dlen_q > CW'(nd_q)) ? (dlen_q - CW'(nd_q)) : '0;
    b1_c    = job_q.left ? '0 : pad_c;
    b2_c    = b1_c + altlen_w;
    b3_c    = b2_c + signlen_w;
    b4_c    = b3_c + zeros_c;
  end

  // Field order: leading spaces, prefix, sign, zero fill, digits, trailing spaces.
  always_comb begin
    emit_digit = 1'b0;
    if (pos_q < b1_q) begin
      emit_ch = CH_SPACE;
    end else if (pos_q < b2_q) begin
      emit_ch = (pos_q == b1_q) ? CH_ZERO : job_q.alt_ch;
    end else if (pos_q < b3_q) begin
      emit_ch = job_q.sign_ch;
    end else if (pos_q < b4_q) begin
      emit_ch = CH_ZERO;
    end else if (pos_q < b5_q) begin
      emit_digit = 1'b1;
      emit_ch    = job_q.is_char ? job_q.mag[7:0]
                                 : digit_char(dig_q[4*didx_q +: 4], job_q.upper);
    end else begin
      emit_ch = CH_SPACE;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          state_d = direct_c ? ST_COUNT : ST_CONV;
        end
      end
      ST_CONV: begin
        if (step_q == 4'd0) begin
          state_d = ST_COUNT;
        end
      end
      ST_COUNT: begin
        state_d = ST_PLAN;
      end
      ST_PLAN: begin
        state_d = (total_c == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && (pos_q == last_q)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop_o = 1'b0;
    emit_go = 1'b0;
    case (state_q)
      ST_IDLE: q_pop_o = q_valid_i;
      ST_EMIT: emit_go = out_free;
      default: begin
        q_pop_o = 1'b0;
        emit_go = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit_go) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q  <= q_job_i;
      sh_q   <= aligned_c;
      step_q <= steps_c;
      dig_q  <= direct_c ? dig_load_c : '0;
    end
    if (state_q == ST_CONV) begin
      sh_q   <= sh_q << 4;
      step_q <= step_q - 4'd1;
      dig_q  <= bcd_c;
    end
    if (state_q == ST_COUNT) begin
      nd_q   <= nd_c;
      dlen_q <= dlen_c;
    end
    if (state_q == ST_PLAN) begin
      b1_q   <= b1_c;
      b2_q   <= b2_c;
      b3_q   <= b3_c;
      b4_q   <= b4_c;
      b5_q   <= b4_c + CW'(nd_q);
      last_q <= total_c - CW'(1);
      pos_q  <= '0;
      didx_q <= IW'(nd_q - NW'(1));
    end
    if (emit_go) begin
      pos_q     <= pos_q + CW'(1);
      m_tdata_q <= emit_ch;
      m_tlast_q <= (pos_q == last_q);
      if (emit_digit) begin
        didx_q <= didx_q - IW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: src/integer_to_text_formatter.sv
// ----------------------------------------------------------------------------
// Integer to text formatter
// Turns one integer conversion into its text, one character per output item.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata                                            tuser / tlast
// s_axis   in   value, has_width, width, has_prec, prec, flags   func, size_sel
// m_axis   out  text_char                                        last_char
//
// An item leaves the queue, goes through digit extraction for a 16-, 32- or
// 64-bit decimal operand (none for octal, hex or char), then the COUNT and
// PLAN layout states, then sends one character per cycle when unstalled.
// The digit converter is shared, so the back end works on one item at a time.
// A two-entry queue lets the input side accept while characters are sent.
// Reset clears the control state only; nothing needs a clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_to_text_formatter_defines.svh"

module integer_to_text_formatter import itf_pkg::*; #(
  parameter int MAX_CHARS = 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [63:0] value, [64] has_width, [71:65] width, [72] has_prec, [78:73] prec,
  // [79] flag_left, [80] flag_plus, [81] flag_space, [82] flag_alt,
  // [83] flag_zero, [87:84] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] func, [4:3] size_sel
  input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [7:0] text_char
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                        m_axis_tlast
);

  logic     push;
  logic     q_ready;
  logic     q_valid;
  logic     q_pop;
  itf_job_t push_job;
  itf_job_t head_job;

  itf_front u_front (
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .q_ready_i  (q_ready),
    .push_o     (push),
    .job_o      (push_job)
  );

  itf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .job_o   (head_job),
    .pop_i   (q_pop)
  );

  itf_back #(
    .MAX_CHARS (MAX_CHARS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_job_i    (head_job),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

  `ITF_ASSERT_SAME(a_push_room, clk_i, rst_ni, push, q_ready, "push into a full queue")
  `ITF_ASSERT_SAME(a_pop_valid, clk_i, rst_ni, q_pop, q_valid, "pop from an empty queue")
  `ITF_ASSERT_NEXT(a_pop_busy, clk_i, rst_ni, q_pop, !q_pop, "back end popped twice in a row")
  `ITF_ASSERT_SAME(a_char_code, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata != 8'd0, "null character sent")

endmodule

`default_nettype wire
